>>> hdl/lfu_pr_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pr_pkg
// Shared types and constants for the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pr_pkg;

   localparam int PAGE_WIDTH      = 7;
   localparam int FRAME_OUT_WIDTH = 3;
   localparam int FAULT_WIDTH     = 16;
   localparam int CSR_WIDTH       = 4;

   localparam logic [CSR_WIDTH-1:0]   CSR_RESET = 4'd8;
   localparam logic [FAULT_WIDTH-1:0] FAULT_MAX = '1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INC,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // sequencer -> datapath
   typedef struct packed {
      logic busy;
      logic clear_we;
      logic inc_we;
      logic issue_en;
      logic finish;
   } seq_ctl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic start;
      logic clear_last;
      logic issue_done;
      logic pipe_empty;
   } seq_status_type;

   // datapath -> compare unit
   typedef struct packed {
      logic clear;
      logic b_valid;
   } scan_ctl_type;

endpackage

>>> hdl/lfu_pr_ram.sv
// ----------------------------------------------------------------------------
// lfu_pr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lfu_pr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lfu_pr_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_pr_ctrl
// Sequencer: count-table clear after reset, count update, frame scan, commit.
// ----------------------------------------------------------------------------
module lfu_pr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  lfu_pr_pkg::seq_status_type status,
   output lfu_pr_pkg::seq_ctl_type    ctl
);

   lfu_pr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfu_pr_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = lfu_pr_pkg::ST_IDLE;
         end
         lfu_pr_pkg::ST_IDLE: begin
            if (status.start) state_in = lfu_pr_pkg::ST_INC;
         end
         lfu_pr_pkg::ST_INC: begin
            state_in = lfu_pr_pkg::ST_SCAN;
         end
         lfu_pr_pkg::ST_SCAN: begin
            if (status.issue_done && status.pipe_empty) state_in = lfu_pr_pkg::ST_FINISH;
         end
         lfu_pr_pkg::ST_FINISH: begin
            state_in = lfu_pr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lfu_pr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         lfu_pr_pkg::ST_CLEAR: begin
            ctl.busy     = 1'b1;
            ctl.clear_we = 1'b1;
         end
         lfu_pr_pkg::ST_IDLE: begin
            ctl.busy = 1'b0;
         end
         lfu_pr_pkg::ST_INC: begin
            // count writeback and first frame read go out together
            ctl.busy     = 1'b1;
            ctl.inc_we   = 1'b1;
            ctl.issue_en = 1'b1;
         end
         lfu_pr_pkg::ST_SCAN: begin
            ctl.busy     = 1'b1;
            ctl.issue_en = 1'b1;
         end
         lfu_pr_pkg::ST_FINISH: begin
            ctl.busy   = 1'b1;
            ctl.finish = 1'b1;
         end
         default: begin
            ctl.busy = 1'b1;
         end
      endcase
   end

endmodule

>>> hdl/lfu_pr_select.sv
// ----------------------------------------------------------------------------
// lfu_pr_select
// Shared compare unit: resident-page match and least-count victim tracking,
// one frame per cycle.
// ----------------------------------------------------------------------------
module lfu_pr_select #(
   parameter int COUNT_WIDTH = 16,
   parameter int FIW         = 3,
   parameter int FCW         = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfu_pr_pkg::scan_ctl_type             ctl,
   input  logic [FIW-1:0]                       b_idx,
   input  logic [lfu_pr_pkg::PAGE_WIDTH-1:0]    b_page,
   input  logic                                 b_in_range,
   input  logic [COUNT_WIDTH-1:0]               c_count,
   input  logic [lfu_pr_pkg::PAGE_WIDTH-1:0]    ref_page,
   input  logic [FCW-1:0]                       filled,
   input  logic [FCW-1:0]                       limit,
   output logic                                 c_busy,
   output logic                                 hit,
   output logic [FIW-1:0]                       hit_idx,
   output logic [FIW-1:0]                       best_idx,
   output logic [lfu_pr_pkg::PAGE_WIDTH-1:0]    best_page
);

   logic                              c_v_ff;
   logic [FIW-1:0]                    c_idx_ff;
   logic [lfu_pr_pkg::PAGE_WIDTH-1:0] c_page_ff;
   logic                              c_oor_ff;
   logic                              hit_ff;
   logic [FIW-1:0]                    hit_idx_ff;
   logic                              best_v_ff;
   logic [COUNT_WIDTH-1:0]            best_cnt_ff;
   logic [FIW-1:0]                    best_idx_ff;
   logic [lfu_pr_pkg::PAGE_WIDTH-1:0] best_page_ff;

   logic                              b_match;
   logic [COUNT_WIDTH-1:0]            eff_count;
   logic                              take;

   assign b_match = ctl.b_valid && !hit_ff && (FCW'(b_idx) < filled) && (b_page == ref_page);

   // pages outside the count table count as zero
   assign eff_count = c_oor_ff ? '0 : c_count;
   assign take = c_v_ff && (FCW'(c_idx_ff) < limit)
                 && (!best_v_ff || (eff_count < best_cnt_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff    <= 1'b0;
         hit_ff    <= 1'b0;
         best_v_ff <= 1'b0;
      end else begin
         c_v_ff <= ctl.b_valid;
         if (ctl.clear) begin
            hit_ff    <= 1'b0;
            best_v_ff <= 1'b0;
         end else begin
            if (b_match) hit_ff <= 1'b1;
            if (take) best_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      c_idx_ff  <= b_idx;
      c_page_ff <= b_page;
      c_oor_ff  <= !b_in_range;
      if (b_match) hit_idx_ff <= b_idx;
      if (take) begin
         best_cnt_ff  <= eff_count;
         best_idx_ff  <= c_idx_ff;
         best_page_ff <= c_page_ff;
      end
   end

   assign c_busy    = c_v_ff;
   assign hit       = hit_ff;
   assign hit_idx   = hit_idx_ff;
   assign best_idx  = best_idx_ff;
   assign best_page = best_page_ff;

endmodule

>>> hdl/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement
// LFU page replacement engine. After reset the use-count table is cleared one
// entry per cycle, busy high, before the first reference is taken. Each
// reference accepted on start (busy low) bumps the page's saturating use
// count, then one compare unit walks the frame table one frame per cycle
// through a three-step read pipeline (frame RAM, count RAM, compare). Busy
// stays high through the count update, the scan of max(filled frames, frame
// limit) frames and the commit. The result is shown for exactly one cycle
// with rsp_valid, in the same cycle that busy drops; there is no backpressure,
// so the receiver must take it then. The user must write frames_in_use through
// csr_wr_en/csr_wr_data while idle only; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lfu_page_replacement #(
   parameter int FRAMES      = 8,
   parameter int PAGE_IDS    = 128,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [lfu_pr_pkg::PAGE_WIDTH-1:0]        req_page_id,
   output logic                                     rsp_valid,
   output logic                                     rsp_hit,
   output logic [lfu_pr_pkg::FRAME_OUT_WIDTH-1:0]   rsp_frame_index,
   output logic                                     rsp_evicted_valid,
   output logic [lfu_pr_pkg::PAGE_WIDTH-1:0]        rsp_evicted_page,
   output logic [lfu_pr_pkg::FAULT_WIDTH-1:0]       rsp_fault_total,
   input  logic                                     csr_wr_en,
   input  logic [lfu_pr_pkg::CSR_WIDTH-1:0]         csr_wr_data
);

   localparam int PW  = lfu_pr_pkg::PAGE_WIDTH;
   localparam int OW  = lfu_pr_pkg::FRAME_OUT_WIDTH;
   localparam int FIW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FCW = $clog2(FRAMES + 1);
   localparam int AW  = $clog2(PAGE_IDS);
   localparam int LW  = 7;

   lfu_pr_pkg::seq_ctl_type    ctl;
   lfu_pr_pkg::seq_status_type status;
   lfu_pr_pkg::scan_ctl_type   scan_ctl;

   logic [lfu_pr_pkg::CSR_WIDTH-1:0]   csr_ff;
   logic [AW-1:0]                      clr_ff;
   logic [PW-1:0]                      page_ff;
   logic [FCW-1:0]                     filled_ff;
   logic [lfu_pr_pkg::FAULT_WIDTH-1:0] fault_ff, fault_in;
   logic [FCW-1:0]                     iss_ff;
   logic                               b_v_ff;
   logic [FIW-1:0]                     b_idx_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_hit_ff;
   logic [OW-1:0]                      rsp_frame_ff;
   logic                               rsp_ev_valid_ff;
   logic [PW-1:0]                      rsp_ev_page_ff;

   logic [LW-1:0]          lim_wide;
   logic [FCW-1:0]         limit;
   logic [FCW-1:0]         scan_n;
   logic                   issue;
   logic                   accept;

   logic [AW+PW-1:0]       req_ext, page_ext, fp_ext;
   logic [AW-1:0]          req_addr, page_addr, fp_addr;
   logic                   page_in_range, fp_in_range;

   logic                   cnt_we;
   logic [AW-1:0]          cnt_wr_addr, cnt_rd_addr;
   logic [COUNT_WIDTH-1:0] cnt_wr_data, cnt_rd_data;

   logic                   frm_we;
   logic [FIW-1:0]         frm_wr_addr;
   logic [PW-1:0]          frm_rd_data;

   logic                   sel_busy, sel_hit;
   logic [FIW-1:0]         hit_idx, best_idx;
   logic [PW-1:0]          best_page;

   logic                   do_fill;
   logic [FIW-1:0]         frame_sel;
   logic [FIW+OW-1:0]      frame_ext;

   // frame limit: 0 acts as 1, anything above FRAMES acts as FRAMES
   always_comb begin
      if (csr_ff == '0) begin
         lim_wide = LW'(1);
      end else if ({3'b000, csr_ff} > LW'(FRAMES)) begin
         lim_wide = LW'(FRAMES);
      end else begin
         lim_wide = {3'b000, csr_ff};
      end
   end
   assign limit  = lim_wide[FCW-1:0];
   assign scan_n = (filled_ff > limit) ? filled_ff : limit;

   assign accept = start && !ctl.busy;
   assign issue  = ctl.issue_en && (iss_ff < scan_n);

   // page id -> count table address and range check
   assign req_ext       = {{AW{1'b0}}, req_page_id};
   assign page_ext      = {{AW{1'b0}}, page_ff};
   assign fp_ext        = {{AW{1'b0}}, frm_rd_data};
   assign req_addr      = req_ext[AW-1:0];
   assign page_addr     = page_ext[AW-1:0];
   assign fp_addr       = fp_ext[AW-1:0];
   assign page_in_range = page_ext < (AW+PW)'(PAGE_IDS);
   assign fp_in_range   = fp_ext < (AW+PW)'(PAGE_IDS);

   // count RAM ports
   always_comb begin
      if (ctl.clear_we) begin
         cnt_we      = 1'b1;
         cnt_wr_addr = clr_ff;
         cnt_wr_data = '0;
      end else begin
         cnt_we      = ctl.inc_we && page_in_range;
         cnt_wr_addr = page_addr;
         cnt_wr_data = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + COUNT_WIDTH'(1);
      end
   end
   // idle: fetch the referenced page's count; scan: fetch the resident page's
   assign cnt_rd_addr = ctl.busy ? fp_addr : req_addr;

   // commit decision
   assign do_fill     = !sel_hit && (filled_ff < limit);
   assign frm_we      = ctl.finish && !sel_hit;
   assign frm_wr_addr = do_fill ? filled_ff[FIW-1:0] : best_idx;
   assign frame_sel   = sel_hit ? hit_idx : frm_wr_addr;
   assign frame_ext   = {{OW{1'b0}}, frame_sel};
   assign fault_in    = (fault_ff == lfu_pr_pkg::FAULT_MAX) ? fault_ff
                        : fault_ff + lfu_pr_pkg::FAULT_WIDTH'(1);

   assign status.start      = start;
   assign status.clear_last = clr_ff == AW'(PAGE_IDS - 1);
   assign status.issue_done = iss_ff == scan_n;
   assign status.pipe_empty = !b_v_ff && !sel_busy;

   assign scan_ctl.clear   = ctl.inc_we;
   assign scan_ctl.b_valid = b_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= lfu_pr_pkg::CSR_RESET;
         clr_ff       <= '0;
         filled_ff    <= '0;
         fault_ff     <= '0;
         iss_ff       <= '0;
         b_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) csr_ff <= csr_wr_data;
         if (ctl.clear_we) clr_ff <= clr_ff + AW'(1);
         if (accept) begin
            iss_ff <= '0;
         end else if (issue) begin
            iss_ff <= iss_ff + FCW'(1);
         end
         b_v_ff       <= issue;
         rsp_valid_ff <= ctl.finish;
         if (ctl.finish && !sel_hit) begin
            fault_ff <= fault_in;
            if (do_fill) filled_ff <= filled_ff + FCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) page_ff <= req_page_id;
      b_idx_ff <= iss_ff[FIW-1:0];
      if (ctl.finish) begin
         rsp_hit_ff      <= sel_hit;
         rsp_frame_ff    <= frame_ext[OW-1:0];
         rsp_ev_valid_ff <= !sel_hit && !do_fill;
         rsp_ev_page_ff  <= (!sel_hit && !do_fill) ? best_page : '0;
      end
   end

   lfu_pr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   lfu_pr_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (PAGE_IDS),
      .AW    (AW)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   lfu_pr_ram #(
      .WIDTH (PW),
      .DEPTH (FRAMES),
      .AW    (FIW)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frm_we),
      .wr_addr (frm_wr_addr),
      .wr_data (page_ff),
      .rd_addr (iss_ff[FIW-1:0]),
      .rd_data (frm_rd_data)
   );

   lfu_pr_select #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .FIW         (FIW),
      .FCW         (FCW)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .b_idx      (b_idx_ff),
      .b_page     (frm_rd_data),
      .b_in_range (fp_in_range),
      .c_count    (cnt_rd_data),
      .ref_page   (page_ff),
      .filled     (filled_ff),
      .limit      (limit),
      .c_busy     (sel_busy),
      .hit        (sel_hit),
      .hit_idx    (hit_idx),
      .best_idx   (best_idx),
      .best_page  (best_page)
   );

   assign busy              = ctl.busy;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = fault_ff;

endmodule
